// ----- src/crt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Types and constants shared by the chunk request tracker modules.
// ----------------------------------------------------------------------------
package crt_pkg;

   localparam logic [19:0] Q_MAX = 20'hFFFFF;
   localparam logic [19:0] DEV_MIN_Q3 = 20'd40;
   localparam logic [19:0] TMO_MIN_MS = 20'd10;

   typedef enum logic [1:0] {
      OP_REQUEST  = 2'd0,
      OP_MANIFEST = 2'd1,
      OP_DATA     = 2'd2,
      OP_TIMEOUT  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CS_IDLE      = 2'd0,
      CS_REQUESTED = 2'd1,
      CS_RECEIVED  = 2'd2,
      CS_TIMED_OUT = 2'd3
   } chunk_state_type;

   typedef enum logic [3:0] {
      RK_ISSUED    = 4'd0,
      RK_NONE      = 4'd1,
      RK_RETRY     = 4'd2,
      RK_IGNORED   = 4'd3,
      RK_DATA_OK   = 4'd4,
      RK_COMPLETE  = 4'd5,
      RK_MANIFEST  = 4'd6,
      RK_NOT_FOUND = 4'd7,
      RK_TOO_LARGE = 4'd8
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MAN_END,
      ST_DATA_RD,
      ST_DATA_EV,
      ST_DATA_DEV,
      ST_TMO_RD,
      ST_TMO_EV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [31:0]        now_ms;
      logic [11:0]        chunk_number;
      logic signed [31:0] file_size;
      logic [15:0]        payload_size;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  result_kind;
      logic [11:0] issued_chunk;
      logic [19:0] timeout_ms;
      logic [19:0] est_rtt_q3;
      logic [19:0] dev_rtt_q3;
      logic [31:0] sent_count;
      logic [31:0] received_count;
      logic [31:0] timeout_count;
      logic [31:0] retransmit_count;
   } rsp_word_type;

   function automatic logic [19:0] sat_q3(input logic [31:0] ms);
      if (ms > 32'd131071) begin
         return Q_MAX;
      end
      return {ms[16:0], 3'b000};
   endfunction

endpackage

// ----- src/crt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_ram
// Single port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module crt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/crt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_div
// Restoring divider, one quotient bit per cycle, 33-bit by 16-bit.
// ----------------------------------------------------------------------------
module crt_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [32:0] quotient
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [32:0] q_ff, q_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] trial;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, q_ff[32]};
      ge      = trial >= {1'b0, dsr_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 6'd33;
         rem_in = '0;
         q_in   = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         rem_in = ge ? 16'(trial - {1'b0, dsr_ff}) : trial[15:0];
         q_in   = {q_ff[31:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- src/chunk_request_tracker_top.sv -----
`timescale 1ns / 1ps
// A manifest runs the 33-step divider unless it is rejected.
// One item at a time: busy stays high until its single result strobe.
// The result strobe is high for exactly one cycle; the receiver cannot stall.
// Reset is synchronous; afterwards a clearing pass writes every chunk entry of
// the status memory (at most 4096 entries) with busy high.
// ----------------------------------------------------------------------------
// chunk_request_tracker_top
// Control state of a chunked download with an RTT estimator and re-requests.
// ----------------------------------------------------------------------------
module chunk_request_tracker_top #(
   parameter int MAX_CHUNKS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  crt_pkg::req_word_type req_data,
   output logic                  rsp_strobe,
   output crt_pkg::rsp_word_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int LIMIT = (MAX_CHUNKS - 1 < 4095) ? MAX_CHUNKS - 1 : 4095;
   localparam int DEPTH = LIMIT + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [32:0] LIMIT_Q = 33'(LIMIT);

   crt_pkg::state_type state_ff, state_in;
   crt_pkg::req_word_type in_ff, in_in;
   crt_pkg::rsp_word_type rsp_ff, rsp_in;
   logic        strobe_ff, strobe_in;

   logic [15:0] init_rtt_ff, init_rtt_in;
   logic [15:0] max_rtt_ff, max_rtt_in;
   logic [19:0] est_ff, est_in;
   logic [19:0] dev_ff, dev_in;
   logic [12:0] last_ff, last_in;
   logic        f_req_ff, f_req_in, f_rcv_ff, f_rcv_in, f_fin_ff, f_fin_in;
   logic [31:0] mstamp_ff, mstamp_in;
   logic [12:0] done_ff, done_in;
   logic [1:0]  status0_ff, status0_in;
   logic [31:0] sent_ff, sent_in, recv_ff, recv_in, tmoc_ff, tmoc_in, retx_ff, retx_in;
   logic [11:0] cur_ff, cur_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [3:0]  kind_ff, kind_in;
   logic [11:0] ichunk_ff, ichunk_in;
   logic [19:0] tmo_ff, tmo_in;
   logic [19:0] sq_ff, sq_in;

   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [33:0]   mem_wdata, mem_rdata;
   logic [1:0]    rd_status;
   logic [31:0]   rd_stamp;
   logic          div_start, div_done;
   logic [32:0]   div_quot, div_dvd;

   logic        accept, cfg_wr;
   logic [22:0] life_sum;
   logic [19:0] life, life_chunk;
   logic [31:0] sample;
   logic [19:0] sq_now, est_dbl, cap, diff, diff_m;
   logic [22:0] est_mix;
   logic [22:0] dev_mix;
   logic        rd_open;

   crt_ram #(.WIDTH(34), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign div_dvd = {1'b0, in_ff.file_size} + {17'd0, in_ff.payload_size} - 33'd1;

   crt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (in_ff.payload_size),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rd_status = mem_rdata[33:32];
   assign rd_stamp  = mem_rdata[31:0];
   assign accept    = start && !busy;
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = paddr[2] ? {16'd0, max_rtt_ff} : {16'd0, init_rtt_ff};

   // Shared arithmetic for the estimator.
   always_comb begin
      life_sum   = {3'b000, est_ff} + {1'b0, dev_ff, 2'b00};
      life       = life_sum[22:3];
      life_chunk = (life < crt_pkg::TMO_MIN_MS) ? crt_pkg::TMO_MIN_MS : life;
      sample     = in_ff.now_ms - mstamp_ff;
      sq_now     = crt_pkg::sat_q3(in_ff.now_ms - rd_stamp);
      est_mix    = {3'b000, est_ff} + {2'b00, est_ff, 1'b0} + {3'b000, sq_now};
      diff       = (sq_ff > est_ff) ? sq_ff - est_ff : est_ff - sq_ff;
      diff_m     = (diff < crt_pkg::DEV_MIN_Q3) ? crt_pkg::DEV_MIN_Q3 : diff;
      dev_mix    = {3'b000, dev_ff} + {2'b00, dev_ff, 1'b0} + {1'b0, dev_ff, 2'b00}
                   + {3'b000, diff_m};
      cap        = {1'b0, max_rtt_ff, 3'b000};
      est_dbl    = est_ff[19] ? crt_pkg::Q_MAX : {est_ff[18:0], 1'b0};
      if (est_dbl > cap) begin
         est_dbl = cap;
      end
      rd_open    = (rd_status == crt_pkg::CS_REQUESTED) ||
                   (rd_status == crt_pkg::CS_TIMED_OUT);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         crt_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = crt_pkg::ST_IDLE;
         end
         crt_pkg::ST_IDLE: begin
            if (accept) state_in = crt_pkg::ST_DECODE;
         end
         crt_pkg::ST_DECODE: begin
            state_in = crt_pkg::ST_RESP;
            unique case (crt_pkg::opcode_type'(in_ff.opcode))
               crt_pkg::OP_REQUEST: begin
                  if (f_req_ff && last_ff != 13'd0) state_in = crt_pkg::ST_SCAN_RD;
               end
               crt_pkg::OP_MANIFEST: begin
                  if (!f_rcv_ff && !in_ff.file_size[31] && in_ff.payload_size != 16'd0)
                     state_in = crt_pkg::ST_DIV_GO;
               end
               crt_pkg::OP_DATA: begin
                  if (in_ff.chunk_number != 12'd0 &&
                      {1'b0, in_ff.chunk_number} <= last_ff)
                     state_in = crt_pkg::ST_DATA_RD;
               end
               crt_pkg::OP_TIMEOUT: begin
                  if (f_rcv_ff && in_ff.chunk_number != 12'd0 &&
                      {1'b0, in_ff.chunk_number} <= last_ff)
                     state_in = crt_pkg::ST_TMO_RD;
               end
            endcase
         end
         crt_pkg::ST_SCAN_RD: state_in = crt_pkg::ST_SCAN_EV;
         crt_pkg::ST_SCAN_EV: begin
            if (!(rd_status == crt_pkg::CS_IDLE || rd_status == crt_pkg::CS_TIMED_OUT) &&
                {1'b0, cur_ff} != last_ff)
               state_in = crt_pkg::ST_SCAN_RD;
            else
               state_in = crt_pkg::ST_RESP;
         end
         crt_pkg::ST_DIV_GO:   state_in = crt_pkg::ST_DIV_WAIT;
         crt_pkg::ST_DIV_WAIT: begin
            if (div_done) state_in = crt_pkg::ST_MAN_END;
         end
         crt_pkg::ST_MAN_END:  state_in = crt_pkg::ST_RESP;
         crt_pkg::ST_DATA_RD:  state_in = crt_pkg::ST_DATA_EV;
         crt_pkg::ST_DATA_EV:  state_in = rd_open ? crt_pkg::ST_DATA_DEV : crt_pkg::ST_RESP;
         crt_pkg::ST_DATA_DEV: state_in = crt_pkg::ST_RESP;
         crt_pkg::ST_TMO_RD:   state_in = crt_pkg::ST_TMO_EV;
         crt_pkg::ST_TMO_EV:   state_in = crt_pkg::ST_RESP;
         crt_pkg::ST_RESP:     state_in = crt_pkg::ST_IDLE;
         default:              state_in = crt_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the controller: memory port, divider start, busy.
   always_comb begin
      busy      = (state_ff != crt_pkg::ST_IDLE);
      mem_we    = 1'b0;
      mem_addr  = cur_ff[AW-1:0];
      mem_wdata = mem_rdata;
      div_start = (state_ff == crt_pkg::ST_DIV_GO);
      unique case (state_ff)
         crt_pkg::ST_CLEAR: begin
            mem_addr  = clr_ff;
            mem_we    = 1'b1;
            mem_wdata = '0;
         end
         crt_pkg::ST_SCAN_EV: begin
            mem_we    = (rd_status == crt_pkg::CS_IDLE) ||
                        (rd_status == crt_pkg::CS_TIMED_OUT);
            mem_wdata = {crt_pkg::CS_REQUESTED, in_ff.now_ms};
         end
         crt_pkg::ST_DATA_EV: begin
            mem_we    = rd_open;
            mem_wdata = {crt_pkg::CS_RECEIVED, rd_stamp};
         end
         crt_pkg::ST_TMO_EV: begin
            mem_we    = (rd_status == crt_pkg::CS_REQUESTED);
            mem_wdata = {crt_pkg::CS_TIMED_OUT, rd_stamp};
         end
         default: begin
         end
      endcase
   end

   // Datapath updates.
   always_comb begin
      in_in       = accept ? req_data : in_ff;
      init_rtt_in = init_rtt_ff;
      max_rtt_in  = max_rtt_ff;
      est_in      = est_ff;
      dev_in      = dev_ff;
      last_in     = last_ff;
      f_req_in    = f_req_ff;
      f_rcv_in    = f_rcv_ff;
      f_fin_in    = f_fin_ff;
      mstamp_in   = mstamp_ff;
      done_in     = done_ff;
      status0_in  = status0_ff;
      sent_in     = sent_ff;
      recv_in     = recv_ff;
      tmoc_in     = tmoc_ff;
      retx_in     = retx_ff;
      cur_in      = cur_ff;
      clr_in      = clr_ff;
      kind_in     = kind_ff;
      ichunk_in   = ichunk_ff;
      tmo_in      = tmo_ff;
      sq_in       = sq_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;

      if (cfg_wr) begin
         if (paddr[2]) begin
            max_rtt_in = pwdata[15:0];
         end else begin
            init_rtt_in = pwdata[15:0];
            if (sent_ff == 32'd0) est_in = {1'b0, pwdata[15:0], 3'b000};
         end
      end

      unique case (state_ff)
         crt_pkg::ST_CLEAR: clr_in = clr_ff + AW'(1);
         crt_pkg::ST_DECODE: begin
            kind_in   = crt_pkg::RK_IGNORED;
            ichunk_in = '0;
            tmo_in    = '0;
            cur_in    = in_ff.chunk_number;
            unique case (crt_pkg::opcode_type'(in_ff.opcode))
               crt_pkg::OP_REQUEST: begin
                  cur_in  = 12'd1;
                  kind_in = crt_pkg::RK_NONE;
                  if (!f_req_ff) begin
                     mstamp_in  = in_ff.now_ms;
                     status0_in = crt_pkg::CS_REQUESTED;
                     f_req_in   = 1'b1;
                     sent_in    = sent_ff + 32'd1;
                     kind_in    = crt_pkg::RK_ISSUED;
                     tmo_in     = life;
                  end
               end
               crt_pkg::OP_MANIFEST: begin
                  recv_in = recv_ff + 32'd1;
                  if (!f_rcv_ff) begin
                     f_rcv_in = 1'b1;
                     if (in_ff.file_size[31])
                        kind_in = crt_pkg::RK_NOT_FOUND;
                     else if (in_ff.payload_size == 16'd0)
                        kind_in = crt_pkg::RK_TOO_LARGE;
                  end
               end
               crt_pkg::OP_DATA: begin
                  recv_in = recv_ff + 32'd1;
               end
               crt_pkg::OP_TIMEOUT: begin
                  if (!f_rcv_ff) begin
                     // Manifest lost before arrival: re-arm it for the next request.
                     if (in_ff.chunk_number == 12'd0 && f_req_ff &&
                         status0_ff == crt_pkg::CS_REQUESTED) begin
                        status0_in = crt_pkg::CS_TIMED_OUT;
                        f_req_in   = 1'b0;
                        kind_in    = crt_pkg::RK_RETRY;
                     end
                  end else if (in_ff.chunk_number == 12'd0 &&
                               status0_ff == crt_pkg::CS_REQUESTED) begin
                     status0_in = crt_pkg::CS_TIMED_OUT;
                     tmoc_in    = tmoc_ff + 32'd1;
                     est_in     = est_dbl;
                     kind_in    = crt_pkg::RK_RETRY;
                  end
               end
            endcase
         end
         crt_pkg::ST_SCAN_EV: begin
            if (rd_status == crt_pkg::CS_IDLE || rd_status == crt_pkg::CS_TIMED_OUT) begin
               if (rd_status == crt_pkg::CS_TIMED_OUT) retx_in = retx_ff + 32'd1;
               sent_in   = sent_ff + 32'd1;
               kind_in   = crt_pkg::RK_ISSUED;
               ichunk_in = cur_ff;
               tmo_in    = life_chunk;
            end else begin
               cur_in = cur_ff + 12'd1;
            end
         end
         crt_pkg::ST_MAN_END: begin
            if (div_quot > LIMIT_Q) begin
               kind_in = crt_pkg::RK_TOO_LARGE;
            end else begin
               last_in    = div_quot[12:0];
               status0_in = crt_pkg::CS_RECEIVED;
               est_in     = crt_pkg::sat_q3(sample);
               dev_in     = crt_pkg::sat_q3({1'b0, sample[31:1]});
               if (div_quot == 33'd0) begin
                  f_fin_in = 1'b1;
                  kind_in  = crt_pkg::RK_COMPLETE;
               end else begin
                  kind_in = crt_pkg::RK_MANIFEST;
               end
            end
         end
         crt_pkg::ST_DATA_EV: begin
            if (rd_open) begin
               done_in = done_ff + 13'd1;
               sq_in   = sq_now;
               est_in  = est_mix[21:2];
            end
         end
         crt_pkg::ST_DATA_DEV: begin
            dev_in  = dev_mix[22:3];
            kind_in = crt_pkg::RK_DATA_OK;
            if (!f_fin_ff && done_ff >= last_ff) begin
               f_fin_in = 1'b1;
               kind_in  = crt_pkg::RK_COMPLETE;
            end
         end
         crt_pkg::ST_TMO_EV: begin
            if (rd_status == crt_pkg::CS_REQUESTED) begin
               tmoc_in = tmoc_ff + 32'd1;
               est_in  = est_dbl;
               kind_in = crt_pkg::RK_RETRY;
            end
         end
         crt_pkg::ST_RESP: begin
            strobe_in               = 1'b1;
            rsp_in.result_kind      = kind_ff;
            rsp_in.issued_chunk     = ichunk_ff;
            rsp_in.timeout_ms       = tmo_ff;
            rsp_in.est_rtt_q3       = est_ff;
            rsp_in.dev_rtt_q3       = dev_ff;
            rsp_in.sent_count       = sent_ff;
            rsp_in.received_count   = recv_ff;
            rsp_in.timeout_count    = tmoc_ff;
            rsp_in.retransmit_count = retx_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= crt_pkg::ST_CLEAR;
         strobe_ff   <= 1'b0;
         init_rtt_ff <= 16'd500;
         max_rtt_ff  <= 16'd500;
         est_ff      <= 20'd4000;
         dev_ff      <= '0;
         last_ff     <= '0;
         f_req_ff    <= 1'b0;
         f_rcv_ff    <= 1'b0;
         f_fin_ff    <= 1'b0;
         mstamp_ff   <= '0;
         done_ff     <= '0;
         status0_ff  <= crt_pkg::CS_IDLE;
         sent_ff     <= '0;
         recv_ff     <= '0;
         tmoc_ff     <= '0;
         retx_ff     <= '0;
         clr_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         strobe_ff   <= strobe_in;
         init_rtt_ff <= init_rtt_in;
         max_rtt_ff  <= max_rtt_in;
         est_ff      <= est_in;
         dev_ff      <= dev_in;
         last_ff     <= last_in;
         f_req_ff    <= f_req_in;
         f_rcv_ff    <= f_rcv_in;
         f_fin_ff    <= f_fin_in;
         mstamp_ff   <= mstamp_in;
         done_ff     <= done_in;
         status0_ff  <= status0_in;
         sent_ff     <= sent_in;
         recv_ff     <= recv_in;
         tmoc_ff     <= tmoc_in;
         retx_ff     <= retx_in;
         clr_ff      <= clr_in;
      end
      in_ff     <= in_in;
      rsp_ff    <= rsp_in;
      cur_ff    <= cur_in;
      kind_ff   <= kind_in;
      ichunk_ff <= ichunk_in;
      tmo_ff    <= tmo_in;
      sq_ff     <= sq_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted word");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without a word in progress");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == crt_pkg::ST_DIV_WAIT)
      else $error("divider finished outside its wait state");
`endif

endmodule

// ----- dv/tb_chunk_request_tracker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunk_request_tracker_top
// Self-checking bench for the chunk request tracker. A directed opening walks
// the manifest handshake, retries and ignored words. A long random download
// with data, timeouts and re-requests follows, plus noise words. A scoreboard
// predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module tb_chunk_request_tracker_top;

   localparam int CHUNK_CAP = 4095;

   class download_scoreboard;
      logic [1:0]  status [4096];
      logic [31:0] stamp [4096];
      logic [19:0] est, dev;
      int unsigned last_chunk, done_chunks;
      bit          man_req, man_rcv, man_fin;
      logic [31:0] man_stamp;
      logic [31:0] sent, rcvd, tmo_cnt, retx;
      logic [15:0] init_rtt, max_rtt;
      crt_pkg::rsp_word_type expected_words [$];
      int          errors, mismatches;

      function new();
         foreach (status[i]) status[i] = crt_pkg::CS_IDLE;
         init_rtt = 16'd500;
         max_rtt = 16'd500;
         est = {1'b0, init_rtt, 3'b000};
         dev = '0;
         last_chunk = 0;
         done_chunks = 0;
         man_stamp = '0;
         sent = '0;
         rcvd = '0;
         tmo_cnt = '0;
         retx = '0;
      endfunction

      function logic [19:0] sat20(logic [63:0] v);
         return (v > 64'hFFFFF) ? 20'hFFFFF : v[19:0];
      endfunction

      function logic [19:0] lifetime();
         return sat20((64'(est) + 64'(dev) * 4) >> 3);
      endfunction

      function void write_reg(int idx, logic [31:0] value);
         if (idx == 0) begin
            init_rtt = value[15:0];
            // The estimate follows the register until the first request goes out.
            if (sent == 0) est = {1'b0, init_rtt, 3'b000};
         end else begin
            max_rtt = value[15:0];
         end
      endfunction

      function crt_pkg::rsp_word_type note_word(crt_pkg::req_word_type w);
         crt_pkg::rsp_word_type r;
         logic [63:0]  chunks, sample;
         logic [19:0]  sq, diff, tmo;
         int unsigned  c;
         r = '0;
         c = w.chunk_number;
         case (w.opcode)
            crt_pkg::OP_REQUEST: begin
               if (!man_req) begin
                  man_stamp = w.now_ms;
                  status[0] = crt_pkg::CS_REQUESTED;
                  man_req = 1;
                  sent++;
                  r.result_kind = crt_pkg::RK_ISSUED;
                  r.timeout_ms = lifetime();
               end else begin
                  r.result_kind = crt_pkg::RK_NONE;
                  for (int i = 1; i <= last_chunk; i++) begin
                     if (status[i] == crt_pkg::CS_IDLE ||
                         status[i] == crt_pkg::CS_TIMED_OUT) begin
                        if (status[i] == crt_pkg::CS_TIMED_OUT) retx++;
                        status[i] = crt_pkg::CS_REQUESTED;
                        stamp[i] = w.now_ms;
                        sent++;
                        tmo = lifetime();
                        r.result_kind = crt_pkg::RK_ISSUED;
                        r.issued_chunk = i[11:0];
                        r.timeout_ms = (tmo < crt_pkg::TMO_MIN_MS) ?
                                       crt_pkg::TMO_MIN_MS : tmo;
                        break;
                     end
                  end
               end
            end
            crt_pkg::OP_MANIFEST: begin
               rcvd++;
               if (man_rcv) begin
                  r.result_kind = crt_pkg::RK_IGNORED;
               end else begin
                  man_rcv = 1;
                  if (w.file_size[31]) begin
                     r.result_kind = crt_pkg::RK_NOT_FOUND;
                  end else if (w.payload_size == 0) begin
                     r.result_kind = crt_pkg::RK_TOO_LARGE;
                  end else begin
                     chunks = ({32'd0, w.file_size} + 64'(w.payload_size) - 1)
                              / 64'(w.payload_size);
                     if (chunks > CHUNK_CAP) begin
                        r.result_kind = crt_pkg::RK_TOO_LARGE;
                     end else begin
                        last_chunk = 32'(chunks);
                        status[0] = crt_pkg::CS_RECEIVED;
                        sample = {32'd0, 32'(w.now_ms - man_stamp)};
                        est = sat20(sample << 3);
                        dev = sat20((sample >> 1) << 3);
                        if (last_chunk == 0) begin
                           man_fin = 1;
                           r.result_kind = crt_pkg::RK_COMPLETE;
                        end else begin
                           r.result_kind = crt_pkg::RK_MANIFEST;
                        end
                     end
                  end
               end
            end
            crt_pkg::OP_DATA: begin
               rcvd++;
               if (c == 0 || c > last_chunk ||
                   !(status[c] == crt_pkg::CS_REQUESTED ||
                     status[c] == crt_pkg::CS_TIMED_OUT)) begin
                  r.result_kind = crt_pkg::RK_IGNORED;
               end else begin
                  status[c] = crt_pkg::CS_RECEIVED;
                  done_chunks++;
                  sq = sat20({32'd0, 32'(w.now_ms - stamp[c])} << 3);
                  est = 20'((64'(est) * 3 + 64'(sq)) >> 2);
                  diff = (sq > est) ? sq - est : est - sq;
                  if (diff < crt_pkg::DEV_MIN_Q3) diff = crt_pkg::DEV_MIN_Q3;
                  dev = 20'((64'(dev) * 7 + 64'(diff)) >> 3);
                  if (!man_fin && done_chunks >= last_chunk) begin
                     man_fin = 1;
                     r.result_kind = crt_pkg::RK_COMPLETE;
                  end else begin
                     r.result_kind = crt_pkg::RK_DATA_OK;
                  end
               end
            end
            default: begin
               if (!man_rcv) begin
                  if (c == 0 && man_req && status[0] == crt_pkg::CS_REQUESTED) begin
                     status[0] = crt_pkg::CS_TIMED_OUT;
                     man_req = 0;
                     r.result_kind = crt_pkg::RK_RETRY;
                  end else begin
                     r.result_kind = crt_pkg::RK_IGNORED;
                  end
               end else if (c > last_chunk || status[c] != crt_pkg::CS_REQUESTED) begin
                  r.result_kind = crt_pkg::RK_IGNORED;
               end else begin
                  status[c] = crt_pkg::CS_TIMED_OUT;
                  tmo_cnt++;
                  est = sat20(64'(est) * 2);
                  if (est > {1'b0, max_rtt, 3'b000}) est = {1'b0, max_rtt, 3'b000};
                  r.result_kind = crt_pkg::RK_RETRY;
               end
            end
         endcase
         r.est_rtt_q3 = est;
         r.dev_rtt_q3 = dev;
         r.sent_count = sent;
         r.received_count = rcvd;
         r.timeout_count = tmo_cnt;
         r.retransmit_count = retx;
         expected_words.push_back(r);
         return r;
      endfunction

      function bit field_ok(string name, longint unsigned e, longint unsigned a);
         if (e == a) return 1;
         if (mismatches < 10)
            $display("MISMATCH %s: expected %0d actual %0d", name, e, a);
         return 0;
      endfunction

      function void check_word(crt_pkg::rsp_word_type a);
         crt_pkg::rsp_word_type e;
         bit ok;
         if (expected_words.size() == 0) begin
            errors++;
            if (mismatches < 10) $display("ERROR: result word with none expected");
            mismatches++;
            return;
         end
         e = expected_words.pop_front();
         ok = field_ok("result_kind", e.result_kind, a.result_kind);
         ok &= field_ok("issued_chunk", e.issued_chunk, a.issued_chunk);
         ok &= field_ok("timeout_ms", e.timeout_ms, a.timeout_ms);
         ok &= field_ok("est_rtt_q3", e.est_rtt_q3, a.est_rtt_q3);
         ok &= field_ok("dev_rtt_q3", e.dev_rtt_q3, a.dev_rtt_q3);
         ok &= field_ok("sent_count", e.sent_count, a.sent_count);
         ok &= field_ok("received_count", e.received_count, a.received_count);
         ok &= field_ok("timeout_count", e.timeout_count, a.timeout_count);
         ok &= field_ok("retransmit_count", e.retransmit_count, a.retransmit_count);
         if (!ok) begin
            errors++;
            mismatches++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         start = 0;
   logic         busy;
   crt_pkg::req_word_type req_data = '0;
   logic         rsp_strobe;
   crt_pkg::rsp_word_type rsp_data;
   logic         psel = 0, penable = 0, pwrite = 0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   download_scoreboard sb = new();
   bit             no_idle = 0;
   logic [31:0]    now = 32'hFFFF_F000;
   int unsigned    issued_pool [$];

   chunk_request_tracker_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_word(rsp_data);
   end

   initial begin
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic csr_write(input int idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= 3'(idx * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      sb.write_reg(idx, value);
   endtask

   // Waits until every expected word has come back and the block is idle.
   task automatic drain();
      while (sb.expected_words.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_word(input crt_pkg::req_word_type w);
      crt_pkg::rsp_word_type e;
      if (!no_idle && $urandom_range(0, 99) < 32)
         repeat ($urandom_range(1, 6)) @(posedge clock);
      @(posedge clock);
      start <= 1;
      req_data <= w;
      do @(posedge clock); while (busy);
      start <= 0;
      e = sb.note_word(w);
      if (e.result_kind == crt_pkg::RK_ISSUED && e.issued_chunk != 0)
         issued_pool.push_back(e.issued_chunk);
   endtask

   task automatic send_op(input crt_pkg::opcode_type op, input int unsigned chunk,
                          input logic [31:0] fsize, input logic [15:0] psize);
      crt_pkg::req_word_type w;
      w.opcode = op;
      w.now_ms = now;
      w.chunk_number = chunk[11:0];
      w.file_size = fsize;
      w.payload_size = psize;
      send_word(w);
   endtask

   task automatic random_word();
      crt_pkg::req_word_type w;
      int unsigned  r, k;
      r = $urandom_range(0, 99);
      if (r < 3) now = $urandom();
      else if (r < 6) now += $urandom_range(100000, 200000);
      else now += $urandom_range(0, 400);
      w.now_ms = now;
      w.chunk_number = '0;
      w.file_size = $urandom();
      w.payload_size = 16'($urandom());
      r = $urandom_range(0, 99);
      if (r < 40) begin
         w.opcode = crt_pkg::OP_REQUEST;
      end else if (r < 90 && issued_pool.size() != 0) begin
         k = $urandom_range(0, issued_pool.size() - 1);
         w.chunk_number = 12'(issued_pool[k]);
         if (r < 76) begin
            w.opcode = crt_pkg::OP_DATA;
            issued_pool.delete(k);
         end else begin
            w.opcode = crt_pkg::OP_TIMEOUT;
         end
      end else begin
         w.opcode = 2'($urandom_range(1, 3));
         w.chunk_number = 12'($urandom_range(0, 4095));
      end
      send_word(w);
   endtask

   initial begin
      logic [15:0] psize;
      int unsigned nchunks;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);
      csr_write(0, 32'd65535);
      csr_write(1, 32'd0);

      // Manifest handshake before any manifest has arrived.
      send_op(crt_pkg::OP_TIMEOUT, 0, 0, 0);
      send_op(crt_pkg::OP_DATA, 4095, 0, 0);
      send_op(crt_pkg::OP_REQUEST, 0, 0, 0);
      send_op(crt_pkg::OP_REQUEST, 0, 0, 0);
      send_op(crt_pkg::OP_TIMEOUT, 5, 0, 0);
      send_op(crt_pkg::OP_TIMEOUT, 0, 0, 0);
      now += 7;
      send_op(crt_pkg::OP_REQUEST, 0, 0, 0);
      drain();
      csr_write(0, 32'd0);
      csr_write(1, 32'd65535);

      psize = 16'($urandom_range(1, 65535));
      nchunks = $urandom_range(450, 550);
      now += 9000;
      send_op(crt_pkg::OP_MANIFEST, 0, (nchunks - 1) * psize + $urandom_range(1, psize),
              psize);
      send_op(crt_pkg::OP_MANIFEST, 0, 32'hFFFF_FFFF, 16'hFFFF);
      send_op(crt_pkg::OP_MANIFEST, 0, 32'h7FFF_FFFF, 16'h0000);
      send_op(crt_pkg::OP_DATA, 0, 0, 0);
      send_op(crt_pkg::OP_TIMEOUT, 0, 0, 0);
      now += 3;
      send_op(crt_pkg::OP_REQUEST, 0, 0, 0);
      send_op(crt_pkg::OP_TIMEOUT, 1, 0, 0);
      send_op(crt_pkg::OP_REQUEST, 0, 0, 0);
      now += 1;
      send_op(crt_pkg::OP_DATA, 1, 0, 0);
      issued_pool.delete();
      send_op(crt_pkg::OP_DATA, 1, 0, 0);
      send_op(crt_pkg::OP_DATA, nchunks + 1, 0, 0);
      send_op(crt_pkg::OP_TIMEOUT, 4095, 0, 0);
      drain();
      csr_write(0, 32'd1234);
      csr_write(1, 32'd2000);

      for (int i = 0; i < 1630; i++) begin
         no_idle = (i >= 300 && i < 500);
         if (i == 800) begin
            drain();
            csr_write(1, 32'd0);
         end else if (i == 1100) begin
            drain();
            csr_write(1, 32'd65535);
            csr_write(0, 32'd65535);
         end
         random_word();
      end

      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/crt_pkg.sv
src/crt_ram.sv
src/crt_div.sv
src/chunk_request_tracker_top.sv
dv/tb_chunk_request_tracker_top.sv
